// ===== rtl/core/tls_hello_parser_macros.svh =====
// Assertion macros shared by the hello parser RTL.
// No dependencies; include before the module header.
`ifndef TLS_HELLO_PARSER_MACROS_SVH
`define TLS_HELLO_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define TLSH_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TLSH_ASSERT(label, prop, msg) \
  `TLSH_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define TLSH_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define TLSH_ASSERT(label, prop, msg)
`endif

`endif

// ===== rtl/core/tlsh_pkg.sv =====
// Types and constants of the TLS hello parser.
// No dependencies; compile first.
package tlsh_pkg;

  localparam int SuiteCap   = 32;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StTrunc    = 3'd1,
    StRecType  = 3'd2,
    StRecVer   = 3'd3,
    StHsType   = 3'd4,
    StHsVer    = 3'd5,
    StSid      = 3'd6
  } tlsh_status_e;

  typedef enum logic [1:0] {
    HelloNone   = 2'd0,
    HelloClient = 2'd1,
    HelloServer = 2'd2
  } tlsh_hello_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] suite_code;
    logic [2:0]  status;
    logic [1:0]  hello_type;
    logic [15:0] hello_version;
    logic [5:0]  suite_total;
    logic [15:0] ext_start;
    logic [15:0] ext_bytes;
    logic        last;
  } tlsh_result_t;

  // Results of one processed byte: cnt entries, first in a, second in b.
  typedef struct packed {
    logic [1:0]   cnt;
    tlsh_result_t a;
    tlsh_result_t b;
  } tlsh_push_t;

endpackage

// ===== rtl/core/tlsh_if.sv =====
// Valid/ready channel interfaces of the TLS hello parser.
// No dependencies.
interface tlsh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_payload;
  modport source (output valid, data_byte, end_of_payload, input ready);
  modport sink (input valid, data_byte, end_of_payload, output ready);
endinterface

interface tlsh_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] suite_code;
  logic [2:0]  status;
  logic [1:0]  hello_type;
  logic [15:0] hello_version;
  logic [5:0]  suite_total;
  logic [15:0] ext_start;
  logic [15:0] ext_bytes;
  logic        last;
  modport source (output valid, kind, suite_code, status, hello_type, hello_version,
                  suite_total, ext_start, ext_bytes, last, input ready);
  modport sink (input valid, kind, suite_code, status, hello_type, hello_version,
                suite_total, ext_start, ext_bytes, last, output ready);
endinterface

interface tlsh_cfg_if;
  logic valid;
  logic ready;
  logic quic_mode;
  modport source (output valid, quic_mode, input ready);
  modport sink (input valid, quic_mode, output ready);
endinterface

// ===== rtl/core/tlsh_parse_core.sv =====
// Input register and byte parser of the TLS hello parser.
// Depends on tlsh_pkg, tlsh_if and tls_hello_parser_macros.svh.
`include "tls_hello_parser_macros.svh"
module tlsh_parse_core
  import tlsh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tlsh_in_if.sink    in_i,
  tlsh_cfg_if.sink   cfg_i,
  input  logic       room_i,
  output tlsh_push_t push_o
);

  typedef enum logic [3:0] {
    PhRec       = 4'd0,
    PhHsType    = 4'd1,
    PhHsLen     = 4'd2,
    PhHsVer     = 4'd3,
    PhRandom    = 4'd4,
    PhSidLen    = 4'd5,
    PhSid       = 4'd6,
    PhCsLen     = 4'd7,
    PhCs        = 4'd8,
    PhSelSuite  = 4'd9,
    PhCompLen   = 4'd10,
    PhComp      = 4'd11,
    PhExtLen    = 4'd12,
    PhExt       = 4'd13,
    PhDone      = 4'd14,
    PhErr       = 4'd15
  } phase_e;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        eop_q, eop_d;
  logic        quic_q, quic_d;

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] fr_q, fr_d;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  hi_q, hi_d;
  logic [5:0]  kept_q, kept_d;
  logic [2:0]  err_q, err_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] ver_q, ver_d;
  logic [15:0] es_q, es_d;
  logic [15:0] el_q, el_d;

  logic        fire;
  logic        in_fire;
  logic        cfg_fire;
  logic        cfg_restart;
  logic        restart;
  logic        restart_mode;
  logic [15:0] fr_dec;
  logic [15:0] acc_new;
  logic [2:0]  rec_idx;
  logic [15:0] suite_val;
  logic        grease;
  logic        suite_hit;
  logic [2:0]  verdict_st;
  tlsh_result_t suite_res;
  tlsh_result_t verdict_res;

  assign fire        = in_valid_q && room_i;
  assign in_i.ready  = !in_valid_q || room_i;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  assign fr_dec    = fr_q - 16'd1;
  assign acc_new   = {acc_q[7:0], byte_q};
  assign rec_idx   = 3'd5 - fr_q[2:0];
  assign suite_val = {hi_q, byte_q};
  assign grease    = (suite_val != 16'd0) && ((suite_val & 16'h0505) == 16'd0) &&
                     (hi_q == byte_q);

  assign cfg_restart  = cfg_fire && (pos_q == 16'd0) &&
                        ((phase_q == PhRec) || (phase_q == PhHsType));
  assign restart      = (fire && eop_q) || cfg_restart;
  assign restart_mode = cfg_restart ? cfg_i.quic_mode : quic_q;

  always_comb begin
    in_valid_d = in_fire ? 1'b1 : (fire ? 1'b0 : in_valid_q);
    byte_d     = in_fire ? in_i.data_byte : byte_q;
    eop_d      = in_fire ? in_i.end_of_payload : eop_q;
    quic_d     = cfg_fire ? cfg_i.quic_mode : quic_q;
  end

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    fr_d      = fr_q;
    acc_d     = acc_q;
    hi_d      = hi_q;
    kept_d    = kept_q;
    err_d     = err_q;
    kind_d    = kind_q;
    ver_d     = ver_q;
    es_d      = es_q;
    el_d      = el_q;
    suite_hit = 1'b0;
    if (fire) begin
      unique case (phase_q)
        PhRec: begin
          if (rec_idx == 3'd0 && byte_q != 8'd22) begin
            err_d = StRecType; phase_d = PhErr;
          end else if (rec_idx == 3'd1 && byte_q != 8'd3) begin
            err_d = StRecVer; phase_d = PhErr;
          end else if (rec_idx == 3'd2 && byte_q > 8'd3) begin
            err_d = StRecVer; phase_d = PhErr;
          end else begin
            fr_d = fr_dec;
            if (fr_dec == 16'd0) begin
              phase_d = PhHsType; fr_d = 16'd1; acc_d = 16'd0;
            end
          end
        end
        PhHsType: begin
          if (byte_q == 8'd1 || byte_q == 8'd2) begin
            kind_d = byte_q[1:0];
            phase_d = PhHsLen; fr_d = 16'd3; acc_d = 16'd0;
          end else begin
            err_d = StHsType; phase_d = PhErr;
          end
        end
        PhHsLen: begin
          fr_d = fr_dec;
          if (fr_dec == 16'd0) begin
            phase_d = PhHsVer; fr_d = 16'd2; acc_d = 16'd0;
          end
        end
        PhHsVer: begin
          if (fr_q == 16'd2) begin
            ver_d = {byte_q, 8'h00};
            fr_d  = 16'd1;
          end else begin
            ver_d = {ver_q[15:8], byte_q};
            if (ver_q[15:8] != 8'd3 || byte_q < 8'd1 || byte_q > 8'd3) begin
              err_d = StHsVer; phase_d = PhErr;
            end else begin
              phase_d = PhRandom; fr_d = 16'd32; acc_d = 16'd0;
            end
          end
        end
        PhRandom: begin
          fr_d = fr_dec;
          if (fr_dec == 16'd0) begin
            phase_d = PhSidLen; fr_d = 16'd1; acc_d = 16'd0;
          end
        end
        PhSidLen: begin
          if (byte_q > 8'd32) begin
            err_d = StSid; phase_d = PhErr;
          end else if (byte_q == 8'd0) begin
            phase_d = (kind_q == HelloClient) ? PhCsLen : PhSelSuite;
            fr_d = 16'd2; acc_d = 16'd0;
          end else begin
            phase_d = PhSid; fr_d = {8'h00, byte_q}; acc_d = 16'd0;
          end
        end
        PhSid: begin
          fr_d = fr_dec;
          if (fr_dec == 16'd0) begin
            phase_d = (kind_q == HelloClient) ? PhCsLen : PhSelSuite;
            fr_d = 16'd2; acc_d = 16'd0;
          end
        end
        PhCsLen: begin
          acc_d = acc_new;
          fr_d  = fr_dec;
          if (fr_dec == 16'd0) begin
            if (acc_new == 16'd0) begin
              phase_d = PhCompLen; fr_d = 16'd1; acc_d = 16'd0;
            end else begin
              phase_d = PhCs; fr_d = acc_new;
            end
          end
        end
        PhCs: begin
          if ((acc_q[0] ^ fr_q[0]) == 1'b0) begin
            hi_d = byte_q;
          end else if (!grease && ({1'b0, kept_q} < 7'(SuiteCap))) begin
            kept_d    = kept_q + 6'd1;
            suite_hit = 1'b1;
          end
          fr_d = fr_dec;
          if (fr_dec == 16'd0) begin
            phase_d = PhCompLen; fr_d = 16'd1; acc_d = 16'd0;
          end
        end
        PhSelSuite, PhComp: begin
          fr_d = fr_dec;
          if (fr_dec == 16'd0) begin
            phase_d = (phase_q == PhSelSuite) ? PhCompLen : PhExtLen;
            fr_d = (phase_q == PhSelSuite) ? 16'd1 : 16'd2;
            acc_d = 16'd0;
          end
        end
        PhCompLen: begin
          if (kind_q != HelloClient || byte_q == 8'd0) begin
            phase_d = PhExtLen; fr_d = 16'd2; acc_d = 16'd0;
          end else begin
            phase_d = PhComp; fr_d = {8'h00, byte_q}; acc_d = 16'd0;
          end
        end
        PhExtLen: begin
          acc_d = acc_new;
          fr_d  = fr_dec;
          if (fr_dec == 16'd0) begin
            es_d    = (pos_q != 16'hFFFF) ? pos_q + 16'd1 : 16'hFFFF;
            el_d    = acc_new;
            phase_d = (acc_new == 16'd0) ? PhDone : PhExt;
            fr_d    = acc_new;
          end
        end
        PhExt: begin
          fr_d = fr_dec;
          if (fr_dec == 16'd0) begin
            phase_d = PhDone;
          end
        end
        PhDone, PhErr: begin
        end
      endcase
      if (pos_q != 16'hFFFF) begin
        pos_d = pos_q + 16'd1;
      end
    end

    if (err_d != StOk) begin
      verdict_st = err_d;
    end else if (phase_d == PhDone) begin
      verdict_st = StOk;
    end else begin
      verdict_st = StTrunc;
    end

    suite_res.kind          = 1'b0;
    suite_res.suite_code    = suite_val;
    suite_res.status        = StOk;
    suite_res.hello_type    = kind_d;
    suite_res.hello_version = ver_d;
    suite_res.suite_total   = kept_d;
    suite_res.ext_start     = 16'd0;
    suite_res.ext_bytes     = 16'd0;
    suite_res.last          = 1'b0;

    verdict_res.kind          = 1'b1;
    verdict_res.suite_code    = 16'd0;
    verdict_res.status        = verdict_st;
    verdict_res.hello_type    = kind_d;
    verdict_res.hello_version = ver_d;
    verdict_res.suite_total   = kept_d;
    verdict_res.ext_start     = (verdict_st == StOk) ? es_d : 16'd0;
    verdict_res.ext_bytes     = (verdict_st == StOk) ? el_d : 16'd0;
    verdict_res.last          = 1'b1;

    push_o.cnt = {1'b0, suite_hit} + {1'b0, fire && eop_q};
    push_o.a   = suite_hit ? suite_res : verdict_res;
    push_o.b   = verdict_res;

    if (restart) begin
      phase_d = restart_mode ? PhHsType : PhRec;
      fr_d    = restart_mode ? 16'd1 : 16'd5;
      pos_d   = 16'd0;
      acc_d   = 16'd0;
      hi_d    = 8'd0;
      kept_d  = 6'd0;
      err_d   = StOk;
      kind_d  = HelloNone;
      ver_d   = 16'd0;
      es_d    = 16'd0;
      el_d    = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      quic_q     <= 1'b0;
      phase_q    <= PhRec;
      pos_q      <= 16'd0;
      fr_q       <= 16'd5;
      acc_q      <= 16'd0;
      hi_q       <= 8'd0;
      kept_q     <= 6'd0;
      err_q      <= StOk;
      kind_q     <= HelloNone;
      ver_q      <= 16'd0;
      es_q       <= 16'd0;
      el_q       <= 16'd0;
    end else begin
      in_valid_q <= in_valid_d;
      quic_q     <= quic_d;
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      fr_q       <= fr_d;
      acc_q      <= acc_d;
      hi_q       <= hi_d;
      kept_q     <= kept_d;
      err_q      <= err_d;
      kind_q     <= kind_d;
      ver_q      <= ver_d;
      es_q       <= es_d;
      el_q       <= el_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    eop_q  <= eop_d;
  end

  `TLSH_ASSERT(a_two_results_order, (push_o.cnt == 2'd2) |-> (!push_o.a.kind && push_o.b.kind),
               "two results of one byte must be suite then verdict")
  `TLSH_ASSERT(a_push_needs_room, (push_o.cnt != 2'd0) |-> room_i,
               "results pushed without output room")
  `TLSH_ASSERT(a_error_sticks, (phase_q == PhErr && !(fire && eop_q)) |=> (phase_q == PhErr),
               "error phase left before end of payload")
endmodule

// ===== rtl/core/tlsh_out_fifo.sv =====
// Result queue of the TLS hello parser: takes up to two results a cycle.
// Depends on tlsh_pkg and tls_hello_parser_macros.svh.
`include "tls_hello_parser_macros.svh"
module tlsh_out_fifo
  import tlsh_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  tlsh_push_t   push_i,
  output logic         room_o,
  output logic         head_valid_o,
  output tlsh_result_t head_o,
  input  logic         pop_i
);

  tlsh_result_t          mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   count_q, count_d;
  logic                  pop;

  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign pop          = pop_i && head_valid_o;
  assign room_o       = (count_q <= FifoCntW'(FifoDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop);
    count_d  = count_q + FifoCntW'(push_i.cnt) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.a;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_q + FifoPtrW'(1)] <= push_i.b;
    end
  end

  `TLSH_ASSERT(a_no_overflow, count_q <= FifoCntW'(FifoDepth),
               "result queue overflow")
  `TLSH_ASSERT(a_push_shows, (count_q == '0 && push_i.cnt != 2'd0) |=> head_valid_o,
               "pushed result not visible")
  `TLSH_ASSERT(a_head_holds, (head_valid_o && !pop_i) |=> (head_valid_o && $stable(head_o)),
               "result changed while stalled")
endmodule

// ===== rtl/core/tls_hello_parser.sv =====
// Top level of the TLS hello parser.
// Depends on tlsh_pkg, tlsh_if, tlsh_parse_core and tlsh_out_fifo.
//
// Usage:
//   in_i carries one payload byte per transaction; end_of_payload marks the
//   last byte. out_o carries cipher suite items (kind 0) and one verdict item
//   (kind 1, last 1) per payload. cfg_i writes quic_mode; write it only while
//   no transaction is in flight. cfg_i.ready is always high.
//   Throughput: one byte per cycle while the queue has room. A byte that ends
//   a payload and also completes a cipher suite yields two results, which leave
//   the queue one after the other. An accepted byte waits in the input register,
//   is parsed from there, and its results are registered into the queue.
//   Results pass through a four-entry queue; when the receiver stalls and
//   fewer than two entries are free, a byte in the input register is held
//   there and in_i.ready drops until room returns.
//   Reset clears the queue, sets quic_mode to 0 and expects a record header.
module tls_hello_parser
  import tlsh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tlsh_in_if.sink    in_i,
  tlsh_cfg_if.sink   cfg_i,
  tlsh_out_if.source out_o
);

  tlsh_push_t   push;
  logic         room;
  logic         head_valid;
  tlsh_result_t head;

  tlsh_parse_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .room_i (room),
    .push_o (push)
  );

  tlsh_out_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .room_o       (room),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (out_o.ready)
  );

  assign out_o.valid         = head_valid;
  assign out_o.kind          = head.kind;
  assign out_o.suite_code    = head.suite_code;
  assign out_o.status        = head.status;
  assign out_o.hello_type    = head.hello_type;
  assign out_o.hello_version = head.hello_version;
  assign out_o.suite_total   = head.suite_total;
  assign out_o.ext_start     = head.ext_start;
  assign out_o.ext_bytes     = head.ext_bytes;
  assign out_o.last          = head.last;
endmodule

// ===== bench/tlsh_result_check.sv =====
`timescale 1ns / 1ps
// Result checker for the TLS hello parser: follows the byte, mode and result channels,
// predicts suite and verdict transactions and compares them in order.
// Depends on tlsh_pkg and the channel interfaces in tlsh_if.
module tlsh_result_check
  import tlsh_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  tlsh_in_if   in_i,
  tlsh_cfg_if  cfg_i,
  tlsh_out_if  res_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam logic [7:0] RecHandshake = 8'd22;
  localparam logic [7:0] TlsMajor     = 8'd3;

  typedef enum logic [3:0] {
    PhRec, PhHsType, PhHsLen, PhHsVer, PhRandom, PhSidLen, PhSid, PhCsLen,
    PhCs, PhSelSuite, PhCompLen, PhComp, PhExtLen, PhExt, PhDone, PhErr
  } parse_phase_e;

  parse_phase_e phase_q;
  logic         quic_q;
  logic [15:0]  pos_q;
  logic [15:0]  remain_q;
  logic [15:0]  len_acc_q;
  logic [7:0]   suite_hi_q;
  logic [5:0]   kept_q;
  logic [2:0]   err_q;
  logic [1:0]   hkind_q;
  logic [15:0]  hver_q;
  logic [15:0]  ext_at_q;
  logic [15:0]  ext_len_q;

  tlsh_result_t suite_verdict_q[$];
  int           fail_count = 0;

  task automatic restart_payload();
    phase_q    = quic_q ? PhHsType : PhRec;
    remain_q   = quic_q ? 16'd1 : 16'd5;
    pos_q      = '0;
    len_acc_q  = '0;
    suite_hi_q = '0;
    kept_q     = '0;
    err_q      = '0;
    hkind_q    = '0;
    hver_q     = '0;
    ext_at_q   = '0;
    ext_len_q  = '0;
  endtask

  task automatic enter_field(parse_phase_e ph, logic [15:0] cnt);
    phase_q   = ph;
    remain_q  = cnt;
    len_acc_q = '0;
  endtask

  task automatic fail_with(tlsh_status_e code);
    err_q   = code;
    phase_q = PhErr;
  endtask

  task automatic after_session_id();
    if (hkind_q == HelloClient) enter_field(PhCsLen, 16'd2);
    else enter_field(PhSelSuite, 16'd2);
  endtask

  function automatic logic is_grease(logic [15:0] v);
    return v != 16'h0000 && (v & 16'h0505) == 16'h0000 && v[15:8] == v[7:0];
  endfunction

  function automatic tlsh_result_t make_result(logic kind, logic [15:0] code, logic [2:0] st,
                                               logic [15:0] es, logic [15:0] eb, logic last);
    tlsh_result_t r;
    r.kind          = kind;
    r.suite_code    = code;
    r.status        = st;
    r.hello_type    = hkind_q;
    r.hello_version = hver_q;
    r.suite_total   = kept_q;
    r.ext_start     = es;
    r.ext_bytes     = eb;
    r.last          = last;
    return r;
  endfunction

  task automatic expect_result(tlsh_result_t r);
    suite_verdict_q.insert(suite_verdict_q.size(), r);
  endtask

  task automatic parse_byte(logic [7:0] b, logic eop);
    logic [15:0] idx;
    logic [15:0] v;
    logic [2:0]  st;
    case (phase_q)
      PhRec: begin
        idx = 16'd5 - remain_q;
        if (idx == 16'd0 && b != RecHandshake) fail_with(StRecType);
        else if (idx == 16'd1 && b != TlsMajor) fail_with(StRecVer);
        else if (idx == 16'd2 && b > TlsMajor) fail_with(StRecVer);
        else begin
          remain_q--;
          if (remain_q == 16'd0) enter_field(PhHsType, 16'd1);
        end
      end
      PhHsType: begin
        if (b == 8'(HelloClient) || b == 8'(HelloServer)) begin
          hkind_q = b[1:0];
          enter_field(PhHsLen, 16'd3);
        end else begin
          fail_with(StHsType);
        end
      end
      PhHsLen: begin
        remain_q--;
        if (remain_q == 16'd0) enter_field(PhHsVer, 16'd2);
      end
      PhHsVer: begin
        if (remain_q == 16'd2) begin
          hver_q   = {b, 8'h00};
          remain_q = 16'd1;
        end else begin
          hver_q[7:0] = b;
          if (hver_q[15:8] != TlsMajor || b < 8'd1 || b > 8'd3) fail_with(StHsVer);
          else enter_field(PhRandom, 16'd32);
        end
      end
      PhRandom: begin
        remain_q--;
        if (remain_q == 16'd0) enter_field(PhSidLen, 16'd1);
      end
      PhSidLen: begin
        if (b > 8'd32) fail_with(StSid);
        else if (b == 8'd0) after_session_id();
        else enter_field(PhSid, {8'h00, b});
      end
      PhSid: begin
        remain_q--;
        if (remain_q == 16'd0) after_session_id();
      end
      PhCsLen: begin
        len_acc_q = {len_acc_q[7:0], b};
        remain_q--;
        if (remain_q == 16'd0) begin
          if (len_acc_q == 16'd0) begin
            enter_field(PhCompLen, 16'd1);
          end else begin
            phase_q  = PhCs;
            remain_q = len_acc_q;
          end
        end
      end
      PhCs: begin
        idx = len_acc_q - remain_q;
        if (!idx[0]) begin
          suite_hi_q = b;
        end else begin
          v = {suite_hi_q, b};
          if (!is_grease(v) && kept_q < SuiteCap) begin
            kept_q++;
            expect_result(make_result(1'b0, v, StOk, '0, '0, 1'b0));
          end
        end
        remain_q--;
        if (remain_q == 16'd0) enter_field(PhCompLen, 16'd1);
      end
      PhSelSuite: begin
        remain_q--;
        if (remain_q == 16'd0) enter_field(PhCompLen, 16'd1);
      end
      PhCompLen: begin
        if (hkind_q != HelloClient || b == 8'd0) enter_field(PhExtLen, 16'd2);
        else enter_field(PhComp, {8'h00, b});
      end
      PhComp: begin
        remain_q--;
        if (remain_q == 16'd0) enter_field(PhExtLen, 16'd2);
      end
      PhExtLen: begin
        len_acc_q = {len_acc_q[7:0], b};
        remain_q--;
        if (remain_q == 16'd0) begin
          ext_at_q  = (pos_q != 16'hFFFF) ? pos_q + 16'd1 : 16'hFFFF;
          ext_len_q = len_acc_q;
          if (ext_len_q == 16'd0) begin
            phase_q = PhDone;
          end else begin
            phase_q  = PhExt;
            remain_q = ext_len_q;
          end
        end
      end
      PhExt: begin
        remain_q--;
        if (remain_q == 16'd0) phase_q = PhDone;
      end
      default: ;
    endcase

    if (pos_q != 16'hFFFF) pos_q++;

    if (eop) begin
      if (err_q != 3'd0) st = err_q;
      else if (phase_q == PhDone) st = StOk;
      else st = StTrunc;
      expect_result(make_result(1'b1, '0, st,
                                (st == StOk) ? ext_at_q : '0,
                                (st == StOk) ? ext_len_q : '0, 1'b1));
      restart_payload();
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) report_mismatch($sformatf("%s expected %h, got %h", name, want, got));
  endtask

  task automatic check_result(tlsh_result_t want);
    compare_field("kind", 16'(want.kind), 16'(res_i.kind));
    compare_field("suite_code", want.suite_code, res_i.suite_code);
    compare_field("status", 16'(want.status), 16'(res_i.status));
    compare_field("hello_type", 16'(want.hello_type), 16'(res_i.hello_type));
    compare_field("hello_version", want.hello_version, res_i.hello_version);
    compare_field("suite_total", 16'(want.suite_total), 16'(res_i.suite_total));
    compare_field("ext_start", want.ext_start, res_i.ext_start);
    compare_field("ext_bytes", want.ext_bytes, res_i.ext_bytes);
    compare_field("last", 16'(want.last), 16'(res_i.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quic_q = 1'b0;
      restart_payload();
      suite_verdict_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (suite_verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, kind %b code %h",
                                    res_i.kind, res_i.suite_code));
        end else begin
          check_result(suite_verdict_q.pop_front());
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        quic_q = cfg_i.quic_mode;
        if (pos_q == 16'd0 && (phase_q == PhRec || phase_q == PhHsType)) restart_payload();
      end
      if (in_i.valid && in_i.ready) parse_byte(in_i.data_byte, in_i.end_of_payload);
    end
    pending_o    <= suite_verdict_q.size();
    fail_count_o <= fail_count;
  end

endmodule

// ===== bench/tls_hello_parser_test.sv =====
`timescale 1ns / 1ps
// Top of the TLS hello parser testbench: clock, reset, hello byte streams and the verdict.
// Depends on tlsh_pkg, tlsh_if, the parser RTL and tlsh_result_check.
module tls_hello_parser_test
  import tlsh_pkg::*;
();

  localparam int         StallLimit   = 2000;
  localparam logic [7:0] RecHandshake = 8'd22;
  localparam logic [7:0] TlsMajor     = 8'd3;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  int   sent_bytes = 0;
  int   payloads = 0;
  int   hs_at;
  bit   quiet = 1'b0;
  bit   calm = 1'b0;
  logic mode_now = 1'b0;
  logic [7:0] pl[$];

  always #6 clk_i = ~clk_i;

  tlsh_in_if  byte_ch ();
  tlsh_cfg_if mode_ch ();
  tlsh_out_if result_ch ();

  tls_hello_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .cfg_i  (mode_ch),
    .out_o  (result_ch)
  );

  tlsh_result_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (byte_ch),
    .cfg_i        (mode_ch),
    .res_i        (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (mode_ch.valid && mode_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_byte(logic [7:0] b);
    pl.insert(pl.size(), b);
  endtask

  // Build one hello into pl; hs_at marks the handshake type byte.
  task automatic build_hello(bit quic, bit client, int n_suites, int sid_len, int comp_len,
                             int ext_len, bit odd_len, int tail);
    int          cs_len;
    logic [15:0] v;
    logic [3:0]  nib;
    pl.delete();
    cs_len = 2 * n_suites + odd_len;
    if (!quic) begin
      add_byte(RecHandshake);
      add_byte(TlsMajor);
      add_byte(8'($urandom_range(0, 3)));
      add_byte(8'($urandom));
      add_byte(8'($urandom));
    end
    hs_at = pl.size();
    add_byte(client ? 8'(HelloClient) : 8'(HelloServer));
    repeat (3) add_byte(8'($urandom));
    add_byte(TlsMajor);
    add_byte(8'($urandom_range(1, 3)));
    repeat (32) add_byte(8'($urandom));
    add_byte(8'(sid_len));
    repeat (sid_len) add_byte(8'($urandom));
    if (client) begin
      add_byte(8'(cs_len >> 8));
      add_byte(8'(cs_len));
      for (int i = 0; i < n_suites; i++) begin
        case ($urandom_range(0, 7))
          0: begin
            nib = 4'($urandom);
            v   = {nib, 4'hA, nib, 4'hA};
          end
          1: v = 16'h0000;
          2: begin
            v[15:8] = 8'($urandom);
            v[7:0]  = v[15:8];
          end
          default: v = 16'($urandom);
        endcase
        add_byte(v[15:8]);
        add_byte(v[7:0]);
      end
      if (odd_len) add_byte(8'($urandom));
      add_byte(8'(comp_len));
      repeat (comp_len) add_byte(8'($urandom));
    end else begin
      repeat (3) add_byte(8'($urandom));
    end
    add_byte(8'(ext_len >> 8));
    add_byte(8'(ext_len));
    repeat (ext_len + tail) add_byte(8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] b, logic eop);
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    byte_ch.valid          <= 1'b1;
    byte_ch.data_byte      <= b;
    byte_ch.end_of_payload <= eop;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_range(int from, int upto, bit close);
    calm = ($urandom_range(0, 3) == 0);
    for (int i = from; i < upto; i++) send_byte(pl[i], close && i == upto - 1);
    if (close) payloads++;
  endtask

  // Hold the byte stream until every expected transaction has left, then settle.
  task automatic drain_results();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(logic m);
    drain_results();
    mode_ch.valid     <= 1'b1;
    mode_ch.quic_mode <= m;
    @(posedge clk_i);
    while (!mode_ch.ready) @(posedge clk_i);
    mode_ch.valid <= 1'b0;
    mode_now = m;
  endtask

  initial begin
    result_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  initial begin
    int  n;
    int  sid;
    int  cnt;
    int  at;
    int  sel;
    bit  client;
    bit  lay;
    rst_ni                 <= 1'b0;
    byte_ch.valid          <= 1'b0;
    byte_ch.data_byte      <= '0;
    byte_ch.end_of_payload <= 1'b0;
    mode_ch.valid          <= 1'b0;
    mode_ch.quic_mode      <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(1'b0);
    build_hello(1'b0, 1'b1, 3, 0, 1, 4, 1'b0, 0);
    send_range(0, pl.size(), 1'b1);
    build_hello(1'b0, 1'b0, 0, 32, 0, 0, 1'b0, 0);
    send_range(0, pl.size(), 1'b1);
    // Overflow the suite cap behind a two-byte suite length; end inside the suite list.
    build_hello(1'b0, 1'b1, 130, 5, 0, 0, 1'b1, 3);
    send_range(0, hs_at + 158, 1'b1);

    build_hello(1'b0, 1'b1, 1, 0, 0, 0, 1'b0, 0);
    pl[0] = 8'd0;
    send_range(0, 4, 1'b1);
    pl[0] = RecHandshake;
    pl[1] = 8'd2;
    send_range(0, 4, 1'b1);
    pl[1] = TlsMajor;
    pl[2] = 8'd255;
    send_range(0, 5, 1'b1);
    pl[2] = 8'd3;
    pl[hs_at] = 8'd0;
    send_range(0, hs_at + 3, 1'b1);
    pl[hs_at] = 8'd255;
    send_range(0, hs_at + 3, 1'b1);
    pl[hs_at] = 8'(HelloClient);
    pl[hs_at + 4] = 8'd4;
    send_range(0, hs_at + 7, 1'b1);
    pl[hs_at + 4] = TlsMajor;
    pl[hs_at + 5] = 8'd0;
    send_range(0, hs_at + 7, 1'b1);
    pl[hs_at + 5] = 8'd4;
    send_range(0, hs_at + 7, 1'b1);
    pl[hs_at + 5] = 8'd3;
    pl[hs_at + 38] = 8'd33;
    send_range(0, hs_at + 42, 1'b1);

    build_hello(1'b0, 1'b1, 2, 0, 1, 3, 1'b0, 0);
    send_range(0, pl.size() - 1, 1'b1);
    send_range(0, 1, 1'b1);

    // Switch mode mid-payload; the current payload keeps its record header.
    build_hello(1'b0, 1'b0, 0, 0, 0, 1, 1'b0, 0);
    send_range(0, 3, 1'b0);
    write_mode(1'b1);
    send_range(3, pl.size(), 1'b1);

    // End the payload on the byte that completes a suite.
    build_hello(1'b1, 1'b1, 3, 0, 0, 0, 1'b0, 0);
    pl[hs_at + 43] = 8'h13;
    pl[hs_at + 44] = 8'h01;
    send_range(0, hs_at + 45, 1'b1);
    pl[0] = 8'd3;
    send_range(0, 2, 1'b1);

    payloads = 0;
    while (sent_bytes < 650 || payloads < 3) begin
      if (sent_bytes >= 600) quiet = 1'b1;
      if ($urandom_range(0, 7) == 0) write_mode(1'($urandom_range(0, 1)));
      else if ($urandom_range(0, 11) == 0) drain_results();
      lay    = mode_now ^ ($urandom_range(0, 15) == 0);
      client = ($urandom_range(0, 3) != 0);
      n      = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 6);
      sid    = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 32) : $urandom_range(0, 2);
      build_hello(lay, client, n, sid, $urandom_range(0, 2),
                  ($urandom_range(0, 29) == 0) ? $urandom_range(256, 270) : $urandom_range(0, 6),
                  ($urandom_range(0, 4) == 0),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      cnt = pl.size();
      sel = $urandom_range(0, 19);
      if (sel < 5) begin
        case ($urandom_range(lay ? 3 : 0, 6))
          0: begin
            at = 0;
            pl[at] ^= 8'($urandom_range(1, 255));
          end
          1: begin
            at = 1;
            pl[at] ^= 8'($urandom_range(1, 255));
          end
          2: begin
            at = 2;
            pl[at] = 8'($urandom_range(4, 255));
          end
          3: begin
            at = hs_at;
            pl[at] = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(3, 255));
          end
          4: begin
            at = hs_at + 4;
            pl[at] ^= 8'($urandom_range(1, 255));
          end
          5: begin
            at = hs_at + 5;
            pl[at] = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(4, 255));
          end
          default: begin
            at = hs_at + 38;
            pl[at] = 8'($urandom_range(33, 255));
          end
        endcase
        cnt = at + 1 + $urandom_range(0, 4);
        if (cnt > pl.size()) cnt = pl.size();
      end else if (sel < 8) begin
        cnt = $urandom_range(1, pl.size() - 1);
      end else if (sel < 10) begin
        pl.delete();
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
        cnt = pl.size();
      end
      send_range(0, cnt, 1'b1);
    end

    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tlsh_pkg.sv
rtl/core/tlsh_if.sv
rtl/core/tlsh_parse_core.sv
rtl/core/tlsh_out_fifo.sv
rtl/core/tls_hello_parser.sv
bench/tlsh_result_check.sv
bench/tls_hello_parser_test.sv
